[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field widths of the command and result ports, command codes and the
// control word that the top level hands to every cell of the row.
// ----------------------------------------------------------------------------
package spq_pkg;

    // fixed port field widths
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int SIZE_W = 5;
    localparam int LOAD_W = 40;

    // parameter defaults
    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;

    // saturation ceiling of the load total
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic ins;   // place the new entry, shift the tail right
        logic pop;   // shift the whole row left by one
    } spq_ctrl_t;

endpackage

[design/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue of process entries
// A row of DEPTH cells keeps id/time pairs in ascending time order, equal
// times in arrival order; insert, pop, a saturating load total and a
// one-cycle result strobe per item.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  command   start in, busy out     command, proc_id, run_time
//  result    done out (strobe)      removed_valid/id/time, head_valid/id/time,
//                                   queue_size, total_load, dropped
//
//  An item is taken at any edge with start high and busy low; busy stays low,
//  so one item may follow another in every cycle.
//  For each item every cell compares its key with the new time and shifts
//  in one step, and the result shows during the following cycle.
//  done is high for exactly that one cycle; the receiver cannot stall it.
//  Reset empties the queue and clears the load total; slot contents are left
//  as they are and are never read before being written.
//
module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = spq_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [spq_pkg::ID_W-1:0]    proc_id,
    input  logic [spq_pkg::TIME_W-1:0]  run_time,
    output logic                        done,
    output logic                        removed_valid,
    output logic [spq_pkg::ID_W-1:0]    removed_id,
    output logic [spq_pkg::TIME_W-1:0]  removed_time,
    output logic                        head_valid,
    output logic [spq_pkg::ID_W-1:0]    head_id,
    output logic [spq_pkg::TIME_W-1:0]  head_time,
    output logic [spq_pkg::SIZE_W-1:0]  queue_size,
    output logic [spq_pkg::LOAD_W-1:0]  total_load,
    output logic                        dropped
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    // sum wide enough for the load plus any key without wrapping
    localparam int SUM_W = ((TIME_BITS > LOAD_W) ? TIME_BITS : LOAD_W) + 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 do_ins;
    logic                 do_pop;
    spq_ctrl_t            ctrl;
    logic [ID_BITS-1:0]   new_id;
    logic [TIME_BITS-1:0] new_time;

    logic [ID_BITS-1:0]   cell_id   [DEPTH];
    logic [TIME_BITS-1:0] cell_time [DEPTH];
    logic                 cell_le   [DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [LOAD_W-1:0]    load_reg;
    logic [LOAD_W-1:0]    load_next;
    logic [SUM_W-1:0]     load_sum;

    logic                 done_reg;
    logic                 removed_valid_reg;
    logic [ID_W-1:0]      removed_id_reg;
    logic [TIME_W-1:0]    removed_time_reg;
    logic                 dropped_reg;

    // every command completes in the cycle it is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full   = (count_reg == FULL);
    assign empty  = (count_reg == '0);
    assign do_ins = accept && (command == CMD_INSERT) && !full;
    assign do_pop = accept && (command == CMD_REMOVE) && !empty;

    assign ctrl.ins = do_ins;
    assign ctrl.pop = do_pop;

    // keep only the stored width of each key field
    assign new_id   = ID_BITS'(proc_id);
    assign new_time = TIME_BITS'(run_time);

    // ---- cell row ---------------------------------------------------------
    // Cell i is occupied when i is below the count. On insert the occupied
    // prefix whose times are <= the key stays put, the first cell past it
    // takes the new entry and every later cell takes its left neighbour's.
    // On pop every cell takes its right neighbour's entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        logic                 left_le;
        logic [ID_BITS-1:0]   left_id;
        logic [TIME_BITS-1:0] left_time;
        logic [ID_BITS-1:0]   right_id;
        logic [TIME_BITS-1:0] right_time;

        if (i == 0)
        begin : g_first
            assign left_le   = 1'b1;
            assign left_id   = '0;
            assign left_time = '0;
        end
        else
        begin : g_link_left
            assign left_le   = cell_le[i-1];
            assign left_id   = cell_id[i-1];
            assign left_time = cell_time[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            // nothing behind the last slot: hold its stale entry
            assign right_id   = cell_id[i];
            assign right_time = cell_time[i];
        end
        else
        begin : g_link_right
            assign right_id   = cell_id[i+1];
            assign right_time = cell_time[i+1];
        end

        spq_cell #(
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (IDX < count_reg),
            .new_id     (new_id),
            .new_time   (new_time),
            .left_le    (left_le),
            .left_id    (left_id),
            .left_time  (left_time),
            .right_id   (right_id),
            .right_time (right_time),
            .le         (cell_le[i]),
            .id         (cell_id[i]),
            .time_val   (cell_time[i])
        );
    end

    // ---- count and load total ---------------------------------------------
    assign load_sum = SUM_W'(load_reg) + SUM_W'(new_time);

    always_comb
    begin
        count_next = count_reg;
        load_next  = load_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
            // saturate at the top of the load range
            if (load_sum > SUM_W'(LOAD_MAX))
                load_next = LOAD_MAX;
            else
                load_next = LOAD_W'(load_sum);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // ---- state and registered result fields -------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            load_reg          <= '0;
            done_reg          <= 1'b0;
            removed_valid_reg <= 1'b0;
            dropped_reg       <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            load_reg          <= load_next;
            done_reg          <= accept;
            removed_valid_reg <= do_pop;
            dropped_reg       <= accept && (command == CMD_INSERT) && full;
        end
    end

    // capture the popped head before the row shifts
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_id_reg   <= do_pop ? ID_W'(cell_id[0]) : '0;
            removed_time_reg <= do_pop ? TIME_W'(cell_time[0]) : '0;
        end
    end

    // head comes straight off the row, size and total off their registers, after the step
    assign done          = done_reg;
    assign removed_valid = removed_valid_reg;
    assign removed_id    = removed_id_reg;
    assign removed_time  = removed_time_reg;
    assign head_valid    = !empty;
    assign head_id       = empty ? '0 : ID_W'(cell_id[0]);
    assign head_time     = empty ? '0 : TIME_W'(cell_time[0]);
    assign queue_size    = SIZE_W'(count_reg);
    assign total_load    = load_reg;
    assign dropped       = dropped_reg;

    // ---- assertions -------------------------------------------------------
    a_done_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("result strobe does not follow the accepted item");

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("queue count beyond depth");

    a_drop_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        done && dropped |-> count_reg == FULL && !removed_valid)
        else $error("insert dropped while the queue had room");

    a_head_ordered : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > CNT_W'(1) |-> cell_time[0] <= cell_time[1])
        else $error("head entry is not the smallest time");

    a_load_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        load_reg >= $past(load_reg))
        else $error("load total decreased");

endmodule

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one id/time pair, compares it with the incoming key and, on each
// accepted command, keeps its entry, takes the new one or takes a neighbour's.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = spq_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  spq_pkg::spq_ctrl_t   ctrl,
    input  logic                 occupied,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic                 left_le,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic [TIME_BITS-1:0] left_time,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [TIME_BITS-1:0] right_time,
    output logic                 le,
    output logic [ID_BITS-1:0]   id,
    output logic [TIME_BITS-1:0] time_val
);
    import spq_pkg::*;

    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [TIME_BITS-1:0] time_next;

    // entry stays ahead of the new key: equal times keep arrival order
    assign le = occupied && (time_reg <= new_time);

    always_comb
    begin
        id_next   = id_reg;
        time_next = time_reg;
        if (ctrl.pop)
        begin
            id_next   = right_id;
            time_next = right_time;
        end
        else if (ctrl.ins && !le)
        begin
            // first slot past the prefix takes the new entry, the rest shift right
            if (left_le)
            begin
                id_next   = new_id;
                time_next = new_time;
            end
            else
            begin
                id_next   = left_id;
                time_next = left_time;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign id       = id_reg;
    assign time_val = time_reg;

endmodule

[tb/spq_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_tb_pkg: result record and shadow queue of the priority queue bench
// Keeps a shadow copy of the ordered queue and the load total. Each accepted
// command queues the result that the block owes. Each strobed result is
// checked field by field against the oldest result still owed.
// ----------------------------------------------------------------------------
package spq_tb_pkg;

    import spq_pkg::*;

    localparam int SLOTS       = DEPTH_DEF;
    localparam int REPORT_CAP  = 10;

    typedef struct packed {
        logic              removed_valid;
        logic [ID_W-1:0]   removed_id;
        logic [TIME_W-1:0] removed_time;
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic [TIME_W-1:0] head_time;
        logic [SIZE_W-1:0] queue_size;
        logic [LOAD_W-1:0] total_load;
        logic              dropped;
    } spq_result_t;

    class spq_shadow;

        logic [ID_W-1:0]   slot_id   [SLOTS];
        logic [TIME_W-1:0] slot_time [SLOTS];
        int unsigned       held;
        logic [LOAD_W-1:0] load;
        spq_result_t       owed_results[$];
        int unsigned       errors;

        function new();
            held   = 0;
            load   = '0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Apply one accepted command to the shadow queue and queue its result.
        function void note_command(logic cmd, logic [ID_W-1:0] pid, logic [TIME_W-1:0] tm);
            spq_result_t       r;
            int unsigned       pos;
            int unsigned       i;
            logic [LOAD_W:0]   sum;
            r = '0;
            if (cmd == CMD_INSERT) begin
                if (held >= SLOTS) begin
                    r.dropped = 1'b1;
                end
                else begin
                    // land after every entry with a time less than or equal
                    pos = 0;
                    while (pos < held && slot_time[pos] <= tm)
                        pos++;
                    for (i = held; i > pos; i--) begin
                        slot_id[i]   = slot_id[i-1];
                        slot_time[i] = slot_time[i-1];
                    end
                    slot_id[pos]   = pid;
                    slot_time[pos] = tm;
                    held++;
                    sum  = {1'b0, load} + {{(LOAD_W + 1 - TIME_W){1'b0}}, tm};
                    load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
                end
            end
            else if (held > 0) begin
                r.removed_valid = 1'b1;
                r.removed_id    = slot_id[0];
                r.removed_time  = slot_time[0];
                for (i = 1; i < held; i++) begin
                    slot_id[i-1]   = slot_id[i];
                    slot_time[i-1] = slot_time[i];
                end
                held--;
            end
            if (held > 0) begin
                r.head_valid = 1'b1;
                r.head_id    = slot_id[0];
                r.head_time  = slot_time[0];
            end
            r.queue_size = SIZE_W'(held);
            r.total_load = load;
            owed_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // Check one strobed result against the oldest one owed.
        function void check_result(spq_result_t got);
            spq_result_t want;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("unexpected result with no command outstanding");
                return;
            end
            want = owed_results.pop_front();
            compare("removed_valid", 64'(want.removed_valid), 64'(got.removed_valid));
            compare("removed_id",    64'(want.removed_id),    64'(got.removed_id));
            compare("removed_time",  64'(want.removed_time),  64'(got.removed_time));
            compare("head_valid",    64'(want.head_valid),    64'(got.head_valid));
            compare("head_id",       64'(want.head_id),       64'(got.head_id));
            compare("head_time",     64'(want.head_time),     64'(got.head_time));
            compare("queue_size",    64'(want.queue_size),    64'(got.queue_size));
            compare("total_load",    64'(want.total_load),    64'(got.total_load));
            compare("dropped",       64'(want.dropped),       64'(got.dropped));
        endfunction

    endclass

endpackage

[tb/sorted_priority_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench of the sorted priority queue
// Drives insert and remove commands through the start/busy handshake and
// checks every strobed result against a shadow queue: ordering and ties,
// drops when full, pops from empty and saturation of the load total.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    import spq_pkg::*;
    import spq_tb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              command;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] run_time;
    logic              done;
    logic              removed_valid;
    logic [ID_W-1:0]   removed_id;
    logic [TIME_W-1:0] removed_time;
    logic              head_valid;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_time;
    logic [SIZE_W-1:0] queue_size;
    logic [LOAD_W-1:0] total_load;
    logic              dropped;

    spq_shadow         shadow;
    spq_result_t       seen;
    int unsigned       idle_pct;

    sorted_priority_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .proc_id       (proc_id),
        .run_time      (run_time),
        .done          (done),
        .removed_valid (removed_valid),
        .removed_id    (removed_id),
        .removed_time  (removed_time),
        .head_valid    (head_valid),
        .head_id       (head_id),
        .head_time     (head_time),
        .queue_size    (queue_size),
        .total_load    (total_load),
        .dropped       (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

    // Result monitor: the strobe lasts one cycle and cannot be held off, so
    // take whatever is on the result ports at every edge that ends a strobe.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            seen.removed_valid = removed_valid;
            seen.removed_id    = removed_id;
            seen.removed_time  = removed_time;
            seen.head_valid    = head_valid;
            seen.head_id       = head_id;
            seen.head_time     = head_time;
            seen.queue_size    = queue_size;
            seen.total_load    = total_load;
            seen.dropped       = dropped;
            shadow.check_result(seen);
        end
    end

    // Present one item on the falling edge, after a random number of idle
    // cycles, and hold it until an edge sees start high with busy low. While
    // idle, wiggle the payload so that nothing is taken without start.
    task automatic issue(input logic cmd, input logic [ID_W-1:0] pid,
                         input logic [TIME_W-1:0] tm);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            command  <= 1'($urandom_range(1));
            proc_id  <= ID_W'($urandom);
            run_time <= $urandom;
            @(negedge clk);
        end
        start    <= 1'b1;
        command  <= cmd;
        proc_id  <= pid;
        run_time <= tm;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_command(cmd, pid, tm);
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    // One random item. Times are a mix of full-range values, a narrow band
    // that forces many ties, the top of the range (which drives the load
    // total into saturation) and the two extremes.
    task automatic send_random(input int unsigned insert_pct);
        logic              cmd;
        logic [TIME_W-1:0] tm;
        int unsigned       pick;
        cmd  = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        pick = $urandom_range(99);
        if (pick < 35)
            tm = $urandom;
        else if (pick < 60)
            tm = TIME_W'($urandom_range(15));
        else if (pick < 80)
            tm = {4'hF, 28'($urandom)};
        else
            tm = $urandom_range(1) ? '1 : '0;
        issue(cmd, ID_W'($urandom), tm);
    endtask

    initial
    begin
        int unsigned phase_idle [3];
        int unsigned bias_pick  [3];
        int unsigned k;

        phase_idle = '{19, 54, 0};
        bias_pick  = '{20, 50, 80};

        // Hold every input at a known value from time zero.
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = CMD_INSERT;
        proc_id  = '0;
        run_time = '0;
        idle_pct = 0;
        shadow   = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: pop from empty with a non-zero payload, which must
        // be ignored; the extreme ids and times; a tie that must keep arrival
        // order; fill to the brim, then an insert that would become the head
        // but must be dropped; pop a couple back out.
        issue(CMD_REMOVE, '1, '1);
        issue(CMD_INSERT, '1, '1);
        issue(CMD_INSERT, '0, '0);
        issue(CMD_INSERT, 16'h1234, 32'd5);
        issue(CMD_INSERT, 16'h4321, 32'd5);
        issue(CMD_REMOVE, '0, '0);
        for (k = 0; k < 13; k++) begin
            if (k[0])
                issue(CMD_INSERT, 16'hAAAA, 32'hAAAA_AAAA);
            else
                issue(CMD_INSERT, 16'h5555 + ID_W'(k), 32'h5555_5555);
        end
        issue(CMD_INSERT, 16'hBEEF, '0);
        issue(CMD_REMOVE, '0, '0);
        issue(CMD_REMOVE, '0, '0);
        drain();

        // Random part: three idling regimes, each in bursts whose insert
        // bias drifts so the queue spends time empty, full and in between.
        // Drain fully between regimes so the sender waits on the block.
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            repeat (16) begin
                k = bias_pick[$urandom_range(2)];
                repeat (40)
                    send_random(k);
            end
            drain();
        end

        // Leave time for any stray strobe to arrive.
        repeat (4) @(posedge clk);

        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

endmodule
